// ===== rtl/slcp_pkg.sv =====
// ============================================================================
// slcp_pkg
// Shared constants, word tables and types of the serial line command parser.
// ============================================================================
`default_nettype none

package slcp_pkg;

    // sizing
    localparam int LINE_CAPACITY   = 64;
    localparam int FRACTION_DIGITS = 4;
    localparam int FRACTION_BITS   = 16;

    localparam int LEN_W   = $clog2(LINE_CAPACITY);
    localparam int POS_W   = 6;
    localparam int POS_MAX = (1 << POS_W) - 1;

    localparam int VALUE_W = 32;
    localparam int INT_W   = VALUE_W - FRACTION_BITS;
    localparam int INT_CAP = 1 << (VALUE_W - 1 - FRACTION_BITS);

    localparam int FRAC_SCALE = 10 ** FRACTION_DIGITS;
    localparam int FRAC_W     = $clog2(FRAC_SCALE);
    localparam int FCNT_W     = $clog2(FRACTION_DIGITS + 1);
    localparam int FRAC_HALF  = FRAC_SCALE / 2;

    // fraction scaling: numerator, reciprocal and product widths
    localparam int NUM_W   = FRAC_W + FRACTION_BITS;
    localparam int RECIP_W = NUM_W - FRAC_W + 1;
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL = (64'd1 << NUM_W) / 64'(FRAC_SCALE);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam int MAG_W   = INT_W + FRACTION_BITS + 1;

    // characters
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SP    = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_GAP   = 8'h20;

    // command kinds
    localparam logic [3:0] KIND_RAW     = 4'd0;
    localparam logic [3:0] KIND_START   = 4'd1;
    localparam logic [3:0] KIND_STOP    = 4'd2;
    localparam logic [3:0] KIND_FORWARD = 4'd3;
    localparam logic [3:0] KIND_REVERSE = 4'd4;
    localparam logic [3:0] KIND_FREQ    = 4'd5;
    localparam logic [3:0] KIND_TORQUE  = 4'd6;
    localparam logic [3:0] KIND_SPEED   = 4'd7;
    localparam logic [3:0] KIND_POLES   = 4'd8;

    // word table; the first four are bare commands, the rest are keys
    localparam int WORD_COUNT    = 9;
    localparam int FIRST_KEY     = 4;
    localparam int WORD_CHARS    = 5;
    localparam int WORD_TEXT_W   = 8 * WORD_CHARS;

    localparam logic [WORD_TEXT_W-1:0] WORD_TEXT [WORD_COUNT] = '{
        "START", {"STOP", 8'h00}, {"FWD", 16'h0000}, {"REV", 16'h0000},
        {"FREQ", 8'h00}, {"TRQ", 16'h0000}, {"SPD", 16'h0000},
        {"POL", 16'h0000}, "POLES"
    };
    localparam logic [2:0] WORD_LEN [WORD_COUNT] = '{
        3'd5, 3'd4, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd5
    };
    localparam logic [3:0] WORD_KIND [WORD_COUNT] = '{
        KIND_START, KIND_STOP, KIND_FORWARD, KIND_REVERSE,
        KIND_FREQ, KIND_TORQUE, KIND_SPEED, KIND_POLES, KIND_POLES
    };

    // number parsing phase
    typedef enum logic [7:0] {
        PH_KEY    = 8'b0000_0001,
        PH_BEFORE = 8'b0000_0010,
        PH_SIGN   = 8'b0000_0100,
        PH_INT    = 8'b0000_1000,
        PH_FRAC   = 8'b0001_0000,
        PH_DONE   = 8'b0010_0000,
        PH_FAIL   = 8'b0100_0000,
        PH_END    = 8'b1000_0000
    } phase_t;

    // finished line handed to the value pipeline
    typedef struct packed {
        logic [3:0]       kind;
        logic [3:0]       poles;
        logic             setting;
        logic             negative;
        logic [INT_W-1:0] int_part;
        logic [NUM_W-1:0] numer;
    } fin_t;

    // character of a word at a position, zero past its end
    function automatic logic [7:0] word_char(input logic [3:0] w, input logic [2:0] p);
        logic [WORD_TEXT_W-1:0] sh;
        sh = WORD_TEXT[w] << {p, 3'b000};
        return sh[WORD_TEXT_W-1 -: 8];
    endfunction

    // 10 to the power n for n up to FRACTION_DIGITS
    function automatic logic [FRAC_W-1:0] pow10(input logic [FCNT_W-1:0] n);
        logic [FRAC_W-1:0] p;
        p = FRAC_W'(1);
        for (int i = 0; i < FRACTION_DIGITS; i++) begin
            if (i < int'(n)) begin
                p = FRAC_W'(p * 10);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/slcp_word_match.sv =====
// ============================================================================
// slcp_word_match
// Keyword matcher: narrows the candidate set per key character and decodes it.
// ============================================================================
`default_nettype none

module slcp_word_match (
    input  wire [slcp_pkg::WORD_COUNT-1:0] cand,
    input  wire [slcp_pkg::POS_W-1:0]      pos,
    input  wire [7:0]                      up_char,
    output logic [slcp_pkg::WORD_COUNT-1:0] key_cand,
    output logic [slcp_pkg::WORD_COUNT-1:0] eq_cand,
    output logic [3:0]                      control_kind,
    output logic [3:0]                      setting_kind
);

    always_comb begin
        logic len_match;
        key_cand     = cand;
        eq_cand      = '0;
        control_kind = slcp_pkg::KIND_RAW;
        setting_kind = slcp_pkg::KIND_RAW;
        for (int i = 0; i < slcp_pkg::WORD_COUNT; i++) begin
            len_match = (pos == slcp_pkg::POS_W'(slcp_pkg::WORD_LEN[i]));
            if (pos >= slcp_pkg::POS_W'(slcp_pkg::WORD_LEN[i]) ||
                slcp_pkg::word_char(4'(i), pos[2:0]) != up_char) begin
                key_cand[i] = 1'b0;
            end
            if (i >= slcp_pkg::FIRST_KEY) begin
                // last full-length key wins on '='
                if (cand[i] && len_match) begin
                    eq_cand = slcp_pkg::WORD_COUNT'(1) << i;
                end
                if (cand[i]) begin
                    setting_kind = slcp_pkg::WORD_KIND[i];
                end
            end else if (cand[i] && len_match) begin
                control_kind = slcp_pkg::WORD_KIND[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/slcp_line_parser.sv =====
// ============================================================================
// slcp_line_parser
// Per-byte line state: length, blank skip, key match and number scanning.
// ============================================================================
`default_nettype none

module slcp_line_parser (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  step_en,
    input  wire [7:0]            rx_byte,
    output logic                 emit,
    output slcp_pkg::fin_t       fin
);

    logic [slcp_pkg::LEN_W-1:0]      len_reg, len_next;
    logic                            skip_reg, skip_next;
    logic [slcp_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [slcp_pkg::WORD_COUNT-1:0] cand_reg, cand_next;
    slcp_pkg::phase_t                phase_reg, phase_next;
    logic                            neg_reg, neg_next;
    logic [slcp_pkg::INT_W-1:0]      int_reg, int_next;
    logic [slcp_pkg::FRAC_W-1:0]     frac_reg, frac_next;
    logic [slcp_pkg::FCNT_W-1:0]     fcnt_reg, fcnt_next;
    logic                            seen_reg, seen_next;

    logic [7:0]                      up_char;
    logic [slcp_pkg::WORD_COUNT-1:0] key_cand, eq_cand;
    logic [3:0]                      control_kind, setting_kind;
    logic                            is_digit, is_space;
    logic [3:0]                      digit;
    logic [slcp_pkg::INT_W+3:0]      int_x10;
    logic [slcp_pkg::INT_W-1:0]      int_add;
    logic [slcp_pkg::FRAC_W+3:0]     frac_x10;
    logic                            clear;

    assign up_char  = (rx_byte >= slcp_pkg::CHAR_LC_A && rx_byte <= slcp_pkg::CHAR_LC_Z) ?
                      rx_byte - slcp_pkg::CASE_GAP : rx_byte;
    assign is_digit = rx_byte >= slcp_pkg::CHAR_ZERO && rx_byte <= slcp_pkg::CHAR_NINE;
    assign is_space = rx_byte == slcp_pkg::CHAR_SP ||
                      (rx_byte >= slcp_pkg::CHAR_TAB && rx_byte <= slcp_pkg::CHAR_CR);
    assign digit    = 4'(rx_byte - slcp_pkg::CHAR_ZERO);

    // integer accumulate with saturation at the cap
    assign int_x10 = {int_reg, 3'b000} + {2'b00, int_reg, 1'b0} +
                     (slcp_pkg::INT_W + 4)'(digit);
    assign int_add = (int_x10 > (slcp_pkg::INT_W + 4)'(slcp_pkg::INT_CAP)) ?
                     slcp_pkg::INT_W'(slcp_pkg::INT_CAP) : int_x10[slcp_pkg::INT_W-1:0];
    assign frac_x10 = {frac_reg, 3'b000} + {2'b00, frac_reg, 1'b0} +
                      (slcp_pkg::FRAC_W + 4)'(digit);

    slcp_word_match u_match (
        .cand         (cand_reg),
        .pos          (pos_reg),
        .up_char      (up_char),
        .key_cand     (key_cand),
        .eq_cand      (eq_cand),
        .control_kind (control_kind),
        .setting_kind (setting_kind)
    );

    always_comb begin
        len_next   = len_reg;
        skip_next  = skip_reg;
        pos_next   = pos_reg;
        cand_next  = cand_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        int_next   = int_reg;
        frac_next  = frac_reg;
        fcnt_next  = fcnt_reg;
        seen_next  = seen_reg;
        emit       = 1'b0;
        clear      = 1'b0;
        if (step_en && rx_byte != slcp_pkg::CHAR_CR) begin
            if (rx_byte == slcp_pkg::CHAR_LF) begin
                if (len_reg != '0) begin
                    emit     = 1'b1;
                    len_next = '0;
                    clear    = 1'b1;
                end
            end else if (len_reg >= slcp_pkg::LEN_W'(slcp_pkg::LINE_CAPACITY - 1)) begin
                // overlong line dropped
                len_next = '0;
                clear    = 1'b1;
            end else begin
                len_next = len_reg + 1'b1;
                if (!(skip_reg && (rx_byte == slcp_pkg::CHAR_SP ||
                                   rx_byte == slcp_pkg::CHAR_TAB))) begin
                    skip_next = 1'b0;
                    case (phase_reg)
                        slcp_pkg::PH_KEY: begin
                            if (rx_byte == slcp_pkg::CHAR_NUL) begin
                                phase_next = slcp_pkg::PH_END;
                            end else if (rx_byte == slcp_pkg::CHAR_EQ) begin
                                cand_next  = eq_cand;
                                phase_next = (|eq_cand) ? slcp_pkg::PH_BEFORE :
                                                          slcp_pkg::PH_FAIL;
                            end else begin
                                cand_next = key_cand;
                                if (pos_reg != slcp_pkg::POS_W'(slcp_pkg::POS_MAX)) begin
                                    pos_next = pos_reg + 1'b1;
                                end
                            end
                        end
                        slcp_pkg::PH_BEFORE: begin
                            if (is_space) begin
                                phase_next = slcp_pkg::PH_BEFORE;
                            end else if (rx_byte == slcp_pkg::CHAR_PLUS ||
                                         rx_byte == slcp_pkg::CHAR_MINUS) begin
                                neg_next   = rx_byte == slcp_pkg::CHAR_MINUS;
                                phase_next = slcp_pkg::PH_SIGN;
                            end else if (is_digit) begin
                                int_next   = int_add;
                                seen_next  = 1'b1;
                                phase_next = slcp_pkg::PH_INT;
                            end else if (rx_byte == slcp_pkg::CHAR_POINT) begin
                                phase_next = slcp_pkg::PH_FRAC;
                            end else begin
                                phase_next = slcp_pkg::PH_FAIL;
                            end
                        end
                        slcp_pkg::PH_SIGN: begin
                            if (is_digit) begin
                                int_next   = int_add;
                                seen_next  = 1'b1;
                                phase_next = slcp_pkg::PH_INT;
                            end else if (rx_byte == slcp_pkg::CHAR_POINT) begin
                                phase_next = slcp_pkg::PH_FRAC;
                            end else begin
                                phase_next = slcp_pkg::PH_FAIL;
                            end
                        end
                        slcp_pkg::PH_INT: begin
                            if (is_digit) begin
                                int_next  = int_add;
                                seen_next = 1'b1;
                            end else if (rx_byte == slcp_pkg::CHAR_POINT) begin
                                phase_next = slcp_pkg::PH_FRAC;
                            end else begin
                                phase_next = slcp_pkg::PH_DONE;
                            end
                        end
                        slcp_pkg::PH_FRAC: begin
                            if (is_digit) begin
                                seen_next = 1'b1;
                                if (fcnt_reg < slcp_pkg::FCNT_W'(slcp_pkg::FRACTION_DIGITS)) begin
                                    frac_next = frac_x10[slcp_pkg::FRAC_W-1:0];
                                    fcnt_next = fcnt_reg + 1'b1;
                                end
                            end else begin
                                phase_next = seen_reg ? slcp_pkg::PH_DONE : slcp_pkg::PH_FAIL;
                            end
                        end
                        default: begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
            if (clear) begin
                skip_next  = 1'b1;
                pos_next   = '0;
                cand_next  = '1;
                phase_next = slcp_pkg::PH_KEY;
                neg_next   = 1'b0;
                int_next   = '0;
                frac_next  = '0;
                fcnt_next  = '0;
                seen_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            skip_reg  <= 1'b1;
            pos_reg   <= '0;
            cand_reg  <= '1;
            phase_reg <= slcp_pkg::PH_KEY;
            neg_reg   <= 1'b0;
            int_reg   <= '0;
            frac_reg  <= '0;
            fcnt_reg  <= '0;
            seen_reg  <= 1'b0;
        end else begin
            len_reg   <= len_next;
            skip_reg  <= skip_next;
            pos_reg   <= pos_next;
            cand_reg  <= cand_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            int_reg   <= int_next;
            frac_reg  <= frac_next;
            fcnt_reg  <= fcnt_next;
            seen_reg  <= seen_next;
        end
    end

    // line summary from the state before the newline
    always_comb begin
        logic [slcp_pkg::FRAC_W-1:0]   pw;
        logic [2*slcp_pkg::FRAC_W-1:0] f4;
        fin.kind     = slcp_pkg::KIND_RAW;
        fin.poles    = 4'd0;
        fin.setting  = 1'b0;
        fin.negative = neg_reg;
        fin.int_part = int_reg;
        // fraction brought to FRACTION_DIGITS digits, then rounding offset added
        pw = slcp_pkg::pow10(slcp_pkg::FCNT_W'(slcp_pkg::FRACTION_DIGITS) - fcnt_reg);
        f4 = frac_reg * pw;
        fin.numer = {f4[slcp_pkg::FRAC_W-1:0], {slcp_pkg::FRACTION_BITS{1'b0}}} +
                    slcp_pkg::NUM_W'(slcp_pkg::FRAC_HALF);
        if (phase_reg == slcp_pkg::PH_KEY || phase_reg == slcp_pkg::PH_END) begin
            fin.kind = control_kind;
        end else if (phase_reg == slcp_pkg::PH_INT || phase_reg == slcp_pkg::PH_DONE ||
                     (phase_reg == slcp_pkg::PH_FRAC && seen_reg)) begin
            if (setting_kind == slcp_pkg::KIND_POLES) begin
                if (!neg_reg && (int_reg == slcp_pkg::INT_W'(2) ||
                                 int_reg == slcp_pkg::INT_W'(4) ||
                                 int_reg == slcp_pkg::INT_W'(6) ||
                                 int_reg == slcp_pkg::INT_W'(8))) begin
                    fin.kind  = slcp_pkg::KIND_POLES;
                    fin.poles = int_reg[3:0];
                end
            end else begin
                fin.kind    = setting_kind;
                fin.setting = setting_kind != slcp_pkg::KIND_RAW;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/slcp_fixed_point.sv =====
// ============================================================================
// slcp_fixed_point
// Value pipeline: fraction scaling by reciprocal, correction, saturation.
// ============================================================================
`default_nettype none

module slcp_fixed_point (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  fin_valid,
    input  wire slcp_pkg::fin_t  fin,
    output logic                 fin_ready,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [39:0]          m_tdata
);

    logic                          st0_valid_reg, st1_valid_reg, st2_valid_reg, out_valid_reg;
    logic                          st0_ready, st1_ready, st2_ready, out_ready;
    slcp_pkg::fin_t                st0_reg, st1_reg, st2_reg;
    logic [slcp_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [slcp_pkg::RECIP_W-1:0]  quot_reg, quot_next;
    logic [slcp_pkg::RECIP_W-1:0]  quot_est;
    logic [slcp_pkg::NUM_W-1:0]    quot_back, rem;
    logic [slcp_pkg::MAG_W-1:0]    mag;
    logic [slcp_pkg::VALUE_W-1:0]  value_next;
    logic [3:0]                    out_kind_reg, out_poles_reg;
    logic [slcp_pkg::VALUE_W-1:0]  out_value_reg;

    assign out_ready = !out_valid_reg || m_tready;
    assign st2_ready = !st2_valid_reg || out_ready;
    assign st1_ready = !st1_valid_reg || st2_ready;
    assign st0_ready = !st0_valid_reg || st1_ready;
    assign fin_ready = st0_ready;

    // reciprocal estimate, low by at most one
    assign prod_next = slcp_pkg::PROD_W'(st0_reg.numer) * slcp_pkg::PROD_W'(slcp_pkg::RECIP);

    assign quot_est  = prod_reg[slcp_pkg::PROD_W-1:slcp_pkg::NUM_W];
    assign quot_back = slcp_pkg::NUM_W'(quot_est) * slcp_pkg::NUM_W'(slcp_pkg::FRAC_SCALE);
    assign rem       = st1_reg.numer - quot_back;
    assign quot_next = quot_est +
                       slcp_pkg::RECIP_W'(rem >= slcp_pkg::NUM_W'(slcp_pkg::FRAC_SCALE));

    // magnitude, then signed saturation
    assign mag = {1'b0, st2_reg.int_part, {slcp_pkg::FRACTION_BITS{1'b0}}} +
                 slcp_pkg::MAG_W'(quot_reg);
    always_comb begin
        if (!st2_reg.setting) begin
            value_next = '0;
        end else if (st2_reg.negative) begin
            value_next = mag[slcp_pkg::MAG_W-1:slcp_pkg::VALUE_W-1] != '0 ?
                         {1'b1, {(slcp_pkg::VALUE_W-1){1'b0}}} :
                         slcp_pkg::VALUE_W'(0) - mag[slcp_pkg::VALUE_W-1:0];
        end else begin
            value_next = mag[slcp_pkg::MAG_W-1:slcp_pkg::VALUE_W-1] != '0 ?
                         {1'b0, {(slcp_pkg::VALUE_W-1){1'b1}}} :
                         mag[slcp_pkg::VALUE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st0_valid_reg <= 1'b0;
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (st0_ready) st0_valid_reg <= fin_valid;
            if (st1_ready) st1_valid_reg <= st0_valid_reg;
            if (st2_ready) st2_valid_reg <= st1_valid_reg;
            if (out_ready) out_valid_reg <= st2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (st0_ready && fin_valid) begin
            st0_reg <= fin;
        end
        if (st1_ready && st0_valid_reg) begin
            st1_reg  <= st0_reg;
            prod_reg <= prod_next;
        end
        if (st2_ready && st1_valid_reg) begin
            st2_reg  <= st1_reg;
            quot_reg <= quot_next;
        end
        if (out_ready && st2_valid_reg) begin
            out_kind_reg  <= st2_reg.kind;
            out_poles_reg <= st2_reg.poles;
            out_value_reg <= value_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_poles_reg, out_value_reg, out_kind_reg};

endmodule

`default_nettype wire

// ===== rtl/serial_line_command_parser.sv =====
// ============================================================================
// serial_line_command_parser
// Line-based command parser for received serial bytes.
// ============================================================================
// throughput: one byte per cycle while the value pipeline has room, set by the
//   single-pass per-byte state update; a command reaches m_tvalid via the stages
//   input register, line parser, reciprocal multiply, correction, output register
// bytes that end no command produce no output
// reset: synchronous active-low aresetn empties the pipeline and starts a new line
`default_nettype none

module serial_line_command_parser (
    input  wire         aclk,
    input  wire         aresetn,
    // byte stream in
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [7:0]   s_tdata,     // [7:0] rx_byte
    // command stream out
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata      // [3:0] command_kind, [35:4] setting_value,
                                     // [39:36] pole_count
);

    // input register
    logic           in_valid_reg;
    logic [7:0]     in_byte_reg;
    logic           fin_ready;
    logic           step_en;
    logic           emit;
    slcp_pkg::fin_t fin;

    // a byte is parsed only when the value pipeline has room for a result
    assign step_en  = in_valid_reg && fin_ready;
    assign s_tready = !in_valid_reg || fin_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // per-byte line state and the summary of a finished line
    slcp_line_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .rx_byte (in_byte_reg),
        .emit    (emit),
        .fin     (fin)
    );

    // fixed-point value and output register
    slcp_fixed_point u_value (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fin_valid (emit),
        .fin       (fin),
        .fin_ready (fin_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // output register empty straight after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // only settings carry a value
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:0] != slcp_pkg::KIND_FREQ &&
        m_tdata[3:0] != slcp_pkg::KIND_TORQUE && m_tdata[3:0] != slcp_pkg::KIND_SPEED
        |-> m_tdata[35:4] == '0)
        else $error("value on a non-setting command");

    // pole count present exactly for the poles kind
    a_poles: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[3:0] == slcp_pkg::KIND_POLES) == (m_tdata[39:36] != 4'd0)))
        else $error("pole count and kind disagree");

    // a result is only parsed when there was room for it
    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> fin_ready && in_valid_reg && in_byte_reg == slcp_pkg::CHAR_LF)
        else $error("line finished without a newline or room");

endmodule

`default_nettype wire
